@@ design/apt_pkg.sv @@
// ---------------------------------------------------------------------------
// apt_pkg: shared types and constants of the affine point transform
// Coordinate format, pipeline stage map, lane interface types and the
// reset matrix.
// ---------------------------------------------------------------------------
package apt_pkg;

  // Fixed-point format of coordinates and coefficients
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // External field and register widths
  localparam int FIELD_W    = 32;
  localparam int REG_W      = 64;
  localparam int HALF_W     = REG_W / 2;
  localparam int NUM_REGS   = 6;
  localparam int CFG_ADDR_W = 3;

  // One lane per matrix row
  localparam int NUM_LANES = 3;

  // Exact product and sum widths (three products plus translation and bias)
  localparam int PROD_W = 2 * COORD_WIDTH;
  localparam int SUM_W  = PROD_W + 3;

  // Pipeline stage map: four lane stages and the output register
  localparam int PIPE_STAGES = 5;
  localparam int STG_MUL     = 0;
  localparam int STG_PAIR    = 1;
  localparam int STG_SUM     = 2;
  localparam int STG_SAT     = 3;
  localparam int STG_OUT     = 4;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [SUM_W-1:0]       sum_t;

  // Round to nearest, ties upward
  localparam sum_t ROUND_BIAS = SUM_W'(64'(1) << (FRAC_BITS - 1));

  // Clamp limits at internal width and as sign-extended output words
  localparam sum_t SAT_MAX = SUM_W'((64'(1) << (COORD_WIDTH - 1)) - 64'(1));
  localparam sum_t SAT_MIN = ~SAT_MAX;
  localparam logic [FIELD_W-1:0] OUT_MAX =
    FIELD_W'((64'(1) << (COORD_WIDTH - 1)) - 64'(1));
  localparam logic [FIELD_W-1:0] OUT_MIN = ~OUT_MAX;

  // Reset matrix: identity
  localparam logic [REG_W-1:0] RST_ROW0_COLS01 = 64'h0000_0000_0001_0000;
  localparam logic [REG_W-1:0] RST_ROW0_COLS23 = 64'h0000_0000_0000_0000;
  localparam logic [REG_W-1:0] RST_ROW1_COLS01 = 64'h0001_0000_0000_0000;
  localparam logic [REG_W-1:0] RST_ROW1_COLS23 = 64'h0000_0000_0000_0000;
  localparam logic [REG_W-1:0] RST_ROW2_COLS01 = 64'h0000_0000_0000_0000;
  localparam logic [REG_W-1:0] RST_ROW2_COLS23 = 64'h0000_0000_0001_0000;

  // Stage load enables from the flow control
  typedef struct packed {
    logic [PIPE_STAGES-1:0] en;
  } apt_ctl_t;

  // One matrix row: three coefficients and the translation
  typedef struct packed {
    coord_t c0;
    coord_t c1;
    coord_t c2;
    coord_t t;
  } apt_row_t;

  // Lane result
  typedef struct packed {
    logic [COORD_WIDTH-1:0] val;
    logic                   sat;
  } apt_lane_res_t;

endpackage

@@ design/affine_point_transform_top.sv @@
// ---------------------------------------------------------------------------
// affine_point_transform_top: 3D affine transform of Q16.16 vectors
// Three row lanes multiply the vector by the upper three matrix rows, add
// the translation for points, round, clamp and merge into one result.
//
//   channel | direction | tdata (low bit up)        | tuser
//   in_     | request in| x_in, y_in, z_in          | kind
//   out_    | result out| x_out, y_out, z_out       | saturated
//   cfg_    | write only| cfg_addr selects register | -
//
// One request per cycle unless stalled; requests pass the multiplier stage,
// two add stages, the round/clamp stage and the output register.
// Reset clears the stage valid bits and loads the identity matrix.
// Stages load whenever empty, so the input stalls only when all five stages
// hold requests and the output is not taken.
// ---------------------------------------------------------------------------
module affine_point_transform_top
  import apt_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  // Request channel
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [NUM_LANES*FIELD_W-1:0] in_tdata,   // x_in, y_in, z_in
  input  logic                         in_tuser,   // kind
  // Result channel
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [NUM_LANES*FIELD_W-1:0] out_tdata,  // x_out, y_out, z_out
  output logic                         out_tuser,  // saturated
  // Configuration
  input  logic                         cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [REG_W-1:0]             cfg_wdata
);

  logic [REG_W-1:0] cfg_r   [NUM_REGS];
  logic [REG_W-1:0] cfg_nxt [NUM_REGS];
  logic [REG_W-1:0] cfg_rst [NUM_REGS];

  apt_ctl_t                       ctl;
  logic [PIPE_STAGES-1:0]         stg_valid;
  apt_row_t [NUM_LANES-1:0]       rows;
  apt_lane_res_t [NUM_LANES-1:0]  lane_res;
  coord_t                         x_c, y_c, z_c;

  // Matrix registers; writes beyond the last register are dropped
  always_comb begin
    cfg_rst[0] = RST_ROW0_COLS01;
    cfg_rst[1] = RST_ROW0_COLS23;
    cfg_rst[2] = RST_ROW1_COLS01;
    cfg_rst[3] = RST_ROW1_COLS23;
    cfg_rst[4] = RST_ROW2_COLS01;
    cfg_rst[5] = RST_ROW2_COLS23;
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_nxt[i] = (cfg_wr_en && cfg_addr == CFG_ADDR_W'(i)) ? cfg_wdata : cfg_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_r[i] <= cfg_rst[i];
      end
    end else begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_r[i] <= cfg_nxt[i];
      end
    end
  end

  // Low coordinate bits of each field
  assign x_c = in_tdata[0*FIELD_W +: COORD_WIDTH];
  assign y_c = in_tdata[1*FIELD_W +: COORD_WIDTH];
  assign z_c = in_tdata[2*FIELD_W +: COORD_WIDTH];

  apt_flow u_flow (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .ctl       (ctl),
    .valid     (stg_valid)
  );

  // One lane per row
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    assign rows[g].c0 = cfg_r[2*g][COORD_WIDTH-1:0];
    assign rows[g].c1 = cfg_r[2*g][HALF_W +: COORD_WIDTH];
    assign rows[g].c2 = cfg_r[2*g+1][COORD_WIDTH-1:0];
    assign rows[g].t  = cfg_r[2*g+1][HALF_W +: COORD_WIDTH];

    apt_lane u_lane (
      .clk  (clk),
      .ctl  (ctl),
      .row  (rows[g]),
      .kind (in_tuser),
      .x    (x_c),
      .y    (y_c),
      .z    (z_c),
      .res  (lane_res[g])
    );
  end

  apt_merge u_merge (
    .clk      (clk),
    .ctl      (ctl),
    .lane_res (lane_res),
    .data     (out_tdata),
    .sat      (out_tuser)
  );

  // A clamped result has at least one coordinate at a range limit
  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      (out_tdata[0*FIELD_W +: FIELD_W] == OUT_MAX ||
       out_tdata[0*FIELD_W +: FIELD_W] == OUT_MIN ||
       out_tdata[1*FIELD_W +: FIELD_W] == OUT_MAX ||
       out_tdata[1*FIELD_W +: FIELD_W] == OUT_MIN ||
       out_tdata[2*FIELD_W +: FIELD_W] == OUT_MAX ||
       out_tdata[2*FIELD_W +: FIELD_W] == OUT_MIN))
    else $error("saturated set with no coordinate at a limit");

  // Input stalls only with a full pipeline and a blocked output
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&stg_valid && !out_tready))
    else $error("input stalled with room in the pipeline");

  // A result taken with another in the clamp stage is replaced next cycle
  a_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && stg_valid[STG_SAT]) |=> out_tvalid)
    else $error("output register not refilled");

endmodule

@@ design/apt_flow.sv @@
// ---------------------------------------------------------------------------
// apt_flow: stage valid tracking and load enables
// Each stage loads when it is empty or its successor moves on, so bubbles
// close up and the input flows while a result waits and a stage is empty.
// ---------------------------------------------------------------------------
module apt_flow
  import apt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output apt_ctl_t               ctl,
  output logic [PIPE_STAGES-1:0] valid
);

  logic [PIPE_STAGES-1:0] vld_r;
  logic [PIPE_STAGES-1:0] vld_nxt;
  logic [PIPE_STAGES-1:0] rdy;

  // Ready ripples back from the output register
  always_comb begin
    rdy[STG_OUT] = !vld_r[STG_OUT] || out_ready;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  // Advance valid bits where a stage loads
  always_comb begin
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int k = 1; k < PIPE_STAGES; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctl.en    = rdy;
  assign in_ready  = rdy[0];
  assign out_valid = vld_r[STG_OUT];
  assign valid     = vld_r;

endmodule

@@ design/apt_lane.sv @@
// ---------------------------------------------------------------------------
// apt_lane: one matrix row times the input vector
// Multiply, pairwise add with the rounding bias, final add, then shift and clamp.
// ---------------------------------------------------------------------------
module apt_lane
  import apt_pkg::*;
(
  input  logic          clk,
  input  apt_ctl_t      ctl,
  input  apt_row_t      row,
  input  logic          kind,
  input  coord_t        x,
  input  coord_t        y,
  input  coord_t        z,
  output apt_lane_res_t res
);

  prod_t p0_r, p1_r, p2_r, tr_r;
  prod_t p0_nxt, p1_nxt, p2_nxt, tr_nxt;
  sum_t  pa_r, pb_r, pa_nxt, pb_nxt;
  sum_t  acc_r, acc_nxt;
  sum_t  sh;
  apt_lane_res_t res_r, res_nxt;

  // Exact products; translation scaled to the product format, dropped for
  // directions
  always_comb begin
    p0_nxt = prod_t'(row.c0) * prod_t'(x);
    p1_nxt = prod_t'(row.c1) * prod_t'(y);
    p2_nxt = prod_t'(row.c2) * prod_t'(z);
    tr_nxt = kind ? '0 : (prod_t'(row.t) <<< FRAC_BITS);
  end

  // Pair up the terms, rounding bias goes in with the translation
  always_comb begin
    pa_nxt = sum_t'(p0_r) + sum_t'(p1_r);
    pb_nxt = sum_t'(p2_r) + sum_t'(tr_r) + ROUND_BIAS;
  end

  assign acc_nxt = pa_r + pb_r;

  // Drop the fraction and clamp to the coordinate range
  always_comb begin
    sh = acc_r >>> FRAC_BITS;
    priority if (sh > SAT_MAX) begin
      res_nxt.val = SAT_MAX[COORD_WIDTH-1:0];
      res_nxt.sat = 1'b1;
    end else if (sh < SAT_MIN) begin
      res_nxt.val = SAT_MIN[COORD_WIDTH-1:0];
      res_nxt.sat = 1'b1;
    end else begin
      res_nxt.val = sh[COORD_WIDTH-1:0];
      res_nxt.sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[STG_MUL]) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
      tr_r <= tr_nxt;
    end
    if (ctl.en[STG_PAIR]) begin
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
    end
    if (ctl.en[STG_SUM]) begin
      acc_r <= acc_nxt;
    end
    if (ctl.en[STG_SAT]) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

@@ design/apt_merge.sv @@
// ---------------------------------------------------------------------------
// apt_merge: output register
// Gathers the three lane results into one result word and combines the
// clamp flags.
// ---------------------------------------------------------------------------
module apt_merge
  import apt_pkg::*;
(
  input  logic                                clk,
  input  apt_ctl_t                            ctl,
  input  apt_lane_res_t [NUM_LANES-1:0]       lane_res,
  output logic [NUM_LANES*FIELD_W-1:0]        data,
  output logic                                sat
);

  logic [NUM_LANES*FIELD_W-1:0] data_r, data_nxt;
  logic                         sat_r, sat_nxt;

  // Sign-extend each coordinate and OR the flags
  always_comb begin
    sat_nxt = 1'b0;
    for (int l = 0; l < NUM_LANES; l++) begin
      data_nxt[l*FIELD_W +: FIELD_W] = FIELD_W'(signed'(lane_res[l].val));
      sat_nxt = sat_nxt | lane_res[l].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[STG_OUT]) begin
      data_r <= data_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign data = data_r;
  assign sat  = sat_r;

endmodule
